>>> src/tlfd_pkg.sv
// ----------------------------------------------------------------------------
// Tank level package
// Shared constants, codes and types of the tank level pipeline.
// ----------------------------------------------------------------------------
package tlfd_pkg;

	localparam int NSTG       = 13;
	localparam int QUO_W      = 10;
	localparam int DIV_FIRST  = NSTG - QUO_W + 1;
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 96;
	localparam int OUT_USER_W = 5;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_CFG_ERR      = 3'd1,
		ST_SENSOR_FAULT = 3'd2,
		ST_ZERO_DIST    = 3'd3,
		ST_BELOW_EMPTY  = 3'd4,
		ST_OVERFLOW     = 3'd5
	} status_t;

	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_OFFSET    = 3'd2;
	localparam logic [2:0] REG_SHAPE     = 3'd3;
	localparam logic [2:0] REG_DIAMETER  = 3'd4;
	localparam logic [2:0] REG_LENGTH    = 3'd5;
	localparam logic [2:0] REG_WIDTH     = 3'd6;
	localparam logic [2:0] REG_FULL_VOL  = 3'd7;

	localparam logic [1:0] SHAPE_CIRC = 2'd0;
	localparam logic [1:0] SHAPE_RECT = 2'd1;

	localparam logic [2:0] CLS_EMPTY  = 3'd1;
	localparam logic [2:0] CLS_LOW    = 3'd2;
	localparam logic [2:0] CLS_MEDIUM = 3'd3;
	localparam logic [2:0] CLS_HIGH   = 3'd4;
	localparam logic [2:0] CLS_FULL   = 3'd5;

	typedef struct packed {
		logic        enable;
		logic [13:0] tank_height_mm;
		logic [11:0] sensor_offset_mm;
		logic [1:0]  tank_shape;
		logic [13:0] diameter_mm;
		logic [13:0] length_mm;
		logic [13:0] width_mm;
		logic [23:0] full_volume_dl;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic        sensor_good;
		logic        level_valid;
		logic [13:0] water_height_mm;
		logic [9:0]  percent_filled;
		logic [9:0]  percent_left;
		logic [23:0] volume_filled_dl;
		logic [23:0] volume_left_dl;
		logic [2:0]  level_class;
		logic [3:0]  fault_code;
	} result_t;

endpackage

>>> src/tlfd_pipe.sv
// ----------------------------------------------------------------------------
// Tank level datapath
// Payload registers of all pipeline stages: checks, height clamp, volume
// scaling and a one-bit-per-stage divider for the fill percentage.
// ----------------------------------------------------------------------------
module tlfd_pipe (
	input  logic              clk,
	input  logic              adv,
	input  tlfd_pkg::cfg_t    cfg,
	input  logic [15:0]       distance_mm,
	input  logic              distance_ok,
	input  logic [3:0]        sensor_fault,
	output tlfd_pkg::result_t res
);
	import tlfd_pkg::*;

	localparam logic [13:0] MAX_DIM   = 14'd10000;
	localparam logic [17:0] PI_Q16    = 18'd205887;
	localparam logic [23:0] PCT_SCALE = 24'd1000;
	localparam logic [36:0] SAT_LIM   = 37'd52428800000;
	localparam logic [24:0] RECIP     = 25'd21990232;
	localparam logic [11:0] VOL_DIV   = 12'd3125;
	localparam logic [23:0] VOL_MAX   = 24'hFFFFFF;

	typedef struct packed {
		status_t            status;
		logic               good;
		logic               valid;
		logic [3:0]         fcode;
		logic signed [17:0] hraw;
		logic [13:0]        height;
		logic [23:0]        num;
		logic [QUO_W-1:0]   quo;
		logic [36:0]        phi;
		logic [36:0]        plo;
		logic [36:0]        y;
		logic               ysat;
		logic [42:0]        pph;
		logic [42:0]        ppl;
		logic [23:0]        q0;
		logic [35:0]        p3;
		logic [23:0]        vol;
		logic [23:0]        vleft;
	} pipe_t;

	function automatic logic [2:0] class_of(input logic [9:0] pct);
		logic [2:0] c;
		if (pct >= 10'd950) c = CLS_FULL;
		else if (pct >= 10'd750) c = CLS_HIGH;
		else if (pct >= 10'd250) c = CLS_MEDIUM;
		else if (pct >= 10'd50) c = CLS_LOW;
		else c = CLS_EMPTY;
		return c;
	endfunction

	logic [27:0] d2_q;
	logic [27:0] lw_q;
	logic [45:0] area_q;
	pipe_t       pipe_s [1:NSTG];
	pipe_t       nxt    [1:NSTG];

	// The area factor follows the registers, through the product registers d2_q and lw_q into area_q.
	always_ff @(posedge clk) begin
		d2_q <= {14'b0, cfg.diameter_mm} * {14'b0, cfg.diameter_mm};
		lw_q <= {14'b0, cfg.length_mm} * {14'b0, cfg.width_mm};
		if (cfg.tank_shape == SHAPE_CIRC) begin
			area_q <= {18'b0, d2_q} * {28'b0, PI_Q16};
		end else begin
			area_q <= {lw_q, 18'b0};
		end
	end

	always_comb begin
		logic        geom_ok;
		logic [23:0] dsh;
		logic [60:0] sum;
		logic        corr;

		geom_ok = 1'b0;
		if (cfg.tank_height_mm != 14'd0 && cfg.tank_height_mm <= MAX_DIM) begin
			if (cfg.tank_shape == SHAPE_CIRC) begin
				geom_ok = cfg.diameter_mm != 14'd0 && cfg.diameter_mm <= MAX_DIM;
			end else if (cfg.tank_shape == SHAPE_RECT) begin
				geom_ok = cfg.length_mm != 14'd0 && cfg.width_mm != 14'd0;
			end
		end

		nxt[1] = '0;
		nxt[1].hraw = $signed({4'b0, cfg.tank_height_mm}) + $signed({6'b0, cfg.sensor_offset_mm})
			- $signed({2'b0, distance_mm});
		if (!cfg.enable || !geom_ok) begin
			nxt[1].status = ST_CFG_ERR;
		end else if (!distance_ok) begin
			nxt[1].status = ST_SENSOR_FAULT;
			nxt[1].fcode  = sensor_fault;
		end else if (distance_mm == 16'd0) begin
			nxt[1].status = ST_ZERO_DIST;
		end else begin
			nxt[1].status = ST_OK;
		end

		for (int k = 2; k <= NSTG; k++) begin
			nxt[k] = pipe_s[k-1];
		end

		if (pipe_s[1].status == ST_OK) begin
			nxt[2].good  = 1'b1;
			nxt[2].valid = 1'b1;
			if (pipe_s[1].hraw < 0) begin
				nxt[2].status = ST_BELOW_EMPTY;
				nxt[2].height = 14'd0;
			end else if (pipe_s[1].hraw > $signed({4'b0, cfg.tank_height_mm})) begin
				nxt[2].status = ST_OVERFLOW;
				nxt[2].height = cfg.tank_height_mm;
			end else begin
				nxt[2].height = pipe_s[1].hraw[13:0];
			end
		end

		nxt[3].num = {10'b0, pipe_s[2].height} * PCT_SCALE;
		nxt[3].phi = {14'b0, area_q[45:23]} * {23'b0, pipe_s[2].height};
		nxt[4].plo = {14'b0, area_q[22:0]} * {23'b0, pipe_s[3].height};
		nxt[5].y   = pipe_s[4].phi + {23'b0, pipe_s[4].plo[36:23]};
		nxt[6].ysat = pipe_s[5].y >= SAT_LIM;
		nxt[6].pph  = {25'b0, pipe_s[5].y[35:18]} * {18'b0, RECIP};
		nxt[7].ppl  = {25'b0, pipe_s[6].y[17:0]} * {18'b0, RECIP};
		sum = {pipe_s[7].pph, 18'b0} + {18'b0, pipe_s[7].ppl};
		nxt[8].q0 = sum[59:36];
		nxt[9].p3 = {12'b0, pipe_s[8].q0} * {24'b0, VOL_DIV};
		corr = pipe_s[9].y >= ({1'b0, pipe_s[9].p3} + {25'b0, VOL_DIV});
		if (pipe_s[9].ysat) begin
			nxt[10].vol = VOL_MAX;
		end else begin
			nxt[10].vol = pipe_s[9].q0 + {23'b0, corr};
		end
		if (cfg.full_volume_dl > pipe_s[10].vol) begin
			nxt[11].vleft = cfg.full_volume_dl - pipe_s[10].vol;
		end else begin
			nxt[11].vleft = 24'd0;
		end

		// Restoring division, one quotient bit per stage, most significant first.
		for (int k = DIV_FIRST; k <= NSTG; k++) begin
			dsh = {10'b0, cfg.tank_height_mm} << (NSTG - k);
			if (pipe_s[k-1].num >= dsh) begin
				nxt[k].num          = pipe_s[k-1].num - dsh;
				nxt[k].quo[NSTG-k]  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= NSTG; k++) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	always_comb begin
		res             = '0;
		res.status      = pipe_s[NSTG].status;
		res.sensor_good = pipe_s[NSTG].good;
		res.level_valid = pipe_s[NSTG].valid;
		res.fault_code  = pipe_s[NSTG].fcode;
		if (pipe_s[NSTG].valid) begin
			res.water_height_mm  = pipe_s[NSTG].height;
			res.percent_filled   = pipe_s[NSTG].quo;
			res.percent_left     = 10'd1000 - pipe_s[NSTG].quo;
			res.volume_filled_dl = pipe_s[NSTG].vol;
			res.volume_left_dl   = pipe_s[NSTG].vleft;
			res.level_class      = class_of(pipe_s[NSTG].quo);
		end
	end

endmodule

>>> src/tank_level_from_distance.sv
// ----------------------------------------------------------------------------
// Tank level from distance
// Turns one sensor distance reading into water height, fill percentage,
// volumes and a level class, with an APB register file for tank geometry.
// ----------------------------------------------------------------------------
// The block takes one reading per clock cycle while s_axis_tready is high and
// delivers one result per reading, in order. The path is a 13-stage pipeline,
// ten stages of which form the one-bit-per-stage divider for the fill
// percentage, followed by an output register. A one-entry skid buffer behind
// the pipeline keeps input transfers going while a result waits at the output,
// until it holds a result itself; the pipeline and the input then stall.
module tank_level_from_distance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// distance_mm [15:0], sensor_fault [19:16], zero fill
	input  logic [tlfd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// distance_ok [0]
	input  logic [tlfd_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// water_height_mm [13:0], percent_filled [23:14], percent_left [33:24],
	// volume_filled_dl [57:34], volume_left_dl [81:58], level_class [84:82],
	// fault_code [88:85], zero fill
	output logic [tlfd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// status [2:0], sensor_good [3], level_valid [4]
	output logic [tlfd_pkg::OUT_USER_W-1:0]    m_axis_tuser,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tlfd_pkg::ADDR_W-1:0]        paddr,
	input  logic [tlfd_pkg::DATA_W-1:0]        pwdata,
	output logic [tlfd_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import tlfd_pkg::*;

	cfg_t          cfg_q;
	logic [NSTG:1] vld_s;
	result_t       res;
	result_t       out_q;
	result_t       skid_q;
	logic          out_vld_q;
	logic          skid_vld_q;
	logic          adv;
	logic          take;
	logic          push;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable           <= 1'b0;
			cfg_q.tank_height_mm   <= 14'd1000;
			cfg_q.sensor_offset_mm <= 12'd0;
			cfg_q.tank_shape       <= SHAPE_CIRC;
			cfg_q.diameter_mm      <= 14'd1000;
			cfg_q.length_mm        <= 14'd1000;
			cfg_q.width_mm         <= 14'd1000;
			cfg_q.full_volume_dl   <= 24'd10000;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:2])
				REG_ENABLE:   cfg_q.enable           <= pwdata[0];
				REG_HEIGHT:   cfg_q.tank_height_mm   <= pwdata[13:0];
				REG_OFFSET:   cfg_q.sensor_offset_mm <= pwdata[11:0];
				REG_SHAPE:    cfg_q.tank_shape       <= pwdata[1:0];
				REG_DIAMETER: cfg_q.diameter_mm      <= pwdata[13:0];
				REG_LENGTH:   cfg_q.length_mm        <= pwdata[13:0];
				REG_WIDTH:    cfg_q.width_mm         <= pwdata[13:0];
				REG_FULL_VOL: cfg_q.full_volume_dl   <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_ENABLE:   prdata = {31'b0, cfg_q.enable};
			REG_HEIGHT:   prdata = {18'b0, cfg_q.tank_height_mm};
			REG_OFFSET:   prdata = {20'b0, cfg_q.sensor_offset_mm};
			REG_SHAPE:    prdata = {30'b0, cfg_q.tank_shape};
			REG_DIAMETER: prdata = {18'b0, cfg_q.diameter_mm};
			REG_LENGTH:   prdata = {18'b0, cfg_q.length_mm};
			REG_WIDTH:    prdata = {18'b0, cfg_q.width_mm};
			REG_FULL_VOL: prdata = {8'b0, cfg_q.full_volume_dl};
			default:      prdata = '0;
		endcase
	end

	// The pipeline moves as long as the skid buffer is empty.
	assign adv           = !skid_vld_q;
	assign s_axis_tready = adv;
	assign take          = out_vld_q && m_axis_tready;
	assign push          = adv && vld_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-1:1], s_axis_tvalid};
		end
	end

	tlfd_pipe u_pipe (
		.clk          (clk),
		.adv          (adv),
		.cfg          (cfg_q),
		.distance_mm  (s_axis_tdata[15:0]),
		.distance_ok  (s_axis_tuser[0]),
		.sensor_fault (s_axis_tdata[19:16]),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_vld_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'b0, out_q.fault_code, out_q.level_class, out_q.volume_left_dl,
		out_q.volume_filled_dl, out_q.percent_left, out_q.percent_filled,
		out_q.water_height_mm};
	assign m_axis_tuser  = {out_q.level_valid, out_q.sensor_good, out_q.status};

endmodule

>>> src/tlfd_check.sv
// ----------------------------------------------------------------------------
// Tank level port checker
// Concurrent assertions on the top level ports, attached by bind.
// ----------------------------------------------------------------------------
module tlfd_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [tlfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [tlfd_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import tlfd_pkg::*;

	logic [2:0] st;
	logic       lvl_valid;

	assign st        = m_axis_tuser[2:0];
	assign lvl_valid = m_axis_tuser[4];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("Stalled output transfer changed.");

	a_no_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st == ST_CFG_ERR || st == ST_SENSOR_FAULT || st == ST_ZERO_DIST) |->
			m_axis_tdata[84:0] == '0 && m_axis_tuser[4:3] == 2'b00)
		else $error("Level figures present on an error result.");

	a_pct_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && lvl_valid |->
			({1'b0, m_axis_tdata[23:14]} + {1'b0, m_axis_tdata[33:24]}) == 11'd1000)
		else $error("Filled and remaining percent do not add up.");

	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st != ST_SENSOR_FAULT |-> m_axis_tdata[88:85] == 4'd0)
		else $error("Fault code set without a sensor fault.");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("Input held off without an output stall.");

endmodule

bind tank_level_from_distance tlfd_check u_tlfd_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
